/* hw/rtl/bpe_pkg.sv */
// ============================================================================
// Byte-pair expander package
// Shared payload types, datapath command and status types, and constants.
// ============================================================================
`default_nettype none

package bpe_pkg;

    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam int MAX_EXPAND_DEFAULT  = 64;
    localparam int PAIR_CODES          = 128;
    localparam int TABLE_IDX_W         = $clog2(PAIR_CODES);

    localparam logic        REQ_LOAD      = 1'b0;
    localparam logic        REQ_CODE      = 1'b1;
    localparam logic [7:0]  CODE_END      = 8'd0;
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    typedef struct packed {
        logic                   req_type;
        logic [TABLE_IDX_W-1:0] table_index;
        logic [7:0]             pair_first;
        logic [7:0]             pair_second;
        logic [7:0]             code_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic       last_of_item;
        logic       truncated;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_MARK,
        OP_LIT_POP,
        OP_LIT_END,
        OP_PUSH,
        OP_TRUNC,
        OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_load;
        logic in_is_end;
        logic cur_is_pair;
        logic lit_limit;
        logic emit_ok;
        logic stack_empty;
        logic overflow;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/bpe_stream_if.sv */
// ============================================================================
// Byte-pair expander stream interface
// Valid/ready channel carrying one payload per transaction.
// ============================================================================
`default_nettype none

interface bpe_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bpe_ctrl.sv */
// ============================================================================
// Byte-pair expander controller
// State machine that sequences loads, end markers and code expansion.
// ============================================================================
`default_nettype none

module bpe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bpe_pkg::dp_status_t status,
    output bpe_pkg::dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MARK  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_PAIR  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   lit_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A literal that is emitted needs the output register whenever it
    // moves a byte into it.
    assign lit_stall = status.emit_ok && !status.out_free &&
                       (status.pend_valid || status.stack_empty);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bpe_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.in_is_load)
                    begin
                        cmd.op = bpe_pkg::OP_LOAD;
                    end
                    else if (status.in_is_end)
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        cmd.op     = bpe_pkg::OP_START;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.op     = bpe_pkg::OP_MARK;
                    state_next = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if (status.cur_is_pair)
                begin
                    state_next = ST_PAIR;
                end
                else if (status.lit_limit)
                begin
                    cmd.op     = bpe_pkg::OP_TRUNC;
                    state_next = ST_FLUSH;
                end
                else if (!lit_stall)
                begin
                    if (status.stack_empty)
                    begin
                        cmd.op = bpe_pkg::OP_LIT_END;
                        if (status.emit_ok && !status.pend_valid)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        cmd.op = bpe_pkg::OP_LIT_POP;
                    end
                end
            end
            ST_PAIR:
            begin
                if (status.overflow)
                begin
                    cmd.op     = bpe_pkg::OP_TRUNC;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.op     = bpe_pkg::OP_PUSH;
                    state_next = ST_EVAL;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.op     = bpe_pkg::OP_FLUSH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/bpe_datapath.sv */
// ============================================================================
// Byte-pair expander datapath
// Pair table, expansion stack, capacity tracking and output staging.
// ============================================================================
`default_nettype none

module bpe_datapath #(
    parameter int STACK_DEPTH = bpe_pkg::STACK_DEPTH_DEFAULT,
    parameter int MAX_EXPAND  = bpe_pkg::MAX_EXPAND_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_data,
    input  wire bpe_pkg::in_item_t  in_item,
    input  wire bpe_pkg::dp_cmd_t   cmd,
    output bpe_pkg::dp_status_t     status,
    bpe_stream_if.source            out_ch
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = $clog2(STACK_DEPTH);
    localparam int LW  = $clog2(MAX_EXPAND + 1);
    localparam logic [SPW-1:0] SP_PUSH_MAX = SPW'(STACK_DEPTH - 2);
    localparam logic [LW-1:0]  LIT_MAX     = LW'(MAX_EXPAND);

    logic [15:0]              max_len_reg;
    logic [15:0]              cap_reg;
    logic [15:0]              cap_next;
    logic [7:0]               cur_reg;
    logic [7:0]               cur_next;
    logic [SPW-1:0]           sp_reg;
    logic [SPW-1:0]           sp_next;
    logic [LW-1:0]            lits_reg;
    logic [LW-1:0]            lits_next;
    logic                     trunc_reg;
    logic                     trunc_next;
    logic                     pend_valid_reg;
    logic                     pend_valid_next;
    logic [7:0]               pend_byte_reg;
    logic [7:0]               pend_byte_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    bpe_pkg::out_item_t       out_item_reg;
    bpe_pkg::out_item_t       out_item_next;

    logic [15:0]              pair_mem [bpe_pkg::PAIR_CODES];
    logic [15:0]              pair_rd_reg;
    logic                     pair_we;

    logic [7:0]               stack_mem [STACK_DEPTH];
    logic [7:0]               stack_rd_reg;
    logic                     stack_we;
    logic [IW-1:0]            stack_wa;
    logic [IW-1:0]            stack_ra;

    logic                     emit_ok;
    logic                     out_free;

    assign emit_ok  = cap_reg > 16'd1;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign status.in_is_load  = in_item.req_type == bpe_pkg::REQ_LOAD;
    assign status.in_is_end   = in_item.code_byte == bpe_pkg::CODE_END;
    assign status.cur_is_pair = cur_reg[7];
    assign status.lit_limit   = lits_reg >= LIT_MAX;
    assign status.emit_ok     = emit_ok;
    assign status.stack_empty = sp_reg == '0;
    assign status.overflow    = sp_reg > SP_PUSH_MAX;
    assign status.pend_valid  = pend_valid_reg;
    assign status.out_free    = out_free;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    assign pair_we  = cmd.op == bpe_pkg::OP_LOAD;
    assign stack_we = cmd.op == bpe_pkg::OP_PUSH;
    assign stack_wa = IW'(sp_reg);
    assign stack_ra = (sp_next == '0) ? '0 : IW'(sp_next - 1'b1);

    always_comb
    begin
        cap_next        = cap_reg;
        cur_next        = cur_reg;
        sp_next         = sp_reg;
        lits_next       = lits_reg;
        trunc_next      = trunc_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_item_next   = out_item_reg;
        case (cmd.op)
            bpe_pkg::OP_START:
            begin
                cur_next   = in_item.code_byte;
                sp_next    = '0;
                lits_next  = '0;
                trunc_next = 1'b0;
            end
            bpe_pkg::OP_MARK:
            begin
                out_valid_next = 1'b1;
                out_item_next  = '{out_byte: 8'd0, end_of_string: 1'b1,
                                   last_of_item: 1'b1, truncated: 1'b0};
                cap_next       = max_len_reg;
            end
            bpe_pkg::OP_LIT_POP, bpe_pkg::OP_LIT_END:
            begin
                lits_next = lits_reg + 1'b1;
                if (emit_ok)
                begin
                    cap_next = cap_reg - 16'd1;
                    if (cmd.op == bpe_pkg::OP_LIT_END && !pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = '{out_byte: cur_reg, end_of_string: 1'b0,
                                           last_of_item: 1'b1, truncated: 1'b0};
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '{out_byte: pend_byte_reg,
                                               end_of_string: 1'b0,
                                               last_of_item: 1'b0,
                                               truncated: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_byte_next  = cur_reg;
                    end
                end
                if (cmd.op == bpe_pkg::OP_LIT_POP)
                begin
                    sp_next  = sp_reg - 1'b1;
                    cur_next = stack_rd_reg;
                end
            end
            bpe_pkg::OP_PUSH:
            begin
                sp_next  = sp_reg + 1'b1;
                cur_next = pair_rd_reg[15:8];
            end
            bpe_pkg::OP_TRUNC:
            begin
                trunc_next = 1'b1;
            end
            bpe_pkg::OP_FLUSH:
            begin
                out_valid_next  = 1'b1;
                out_item_next   = '{out_byte: pend_byte_reg, end_of_string: 1'b0,
                                    last_of_item: 1'b1, truncated: trunc_reg};
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= bpe_pkg::MAX_LEN_RESET;
            cap_reg        <= bpe_pkg::MAX_LEN_RESET;
            sp_reg         <= '0;
            lits_reg       <= '0;
            trunc_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
            cap_reg        <= cap_next;
            sp_reg         <= sp_next;
            lits_reg       <= lits_next;
            trunc_reg      <= trunc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pend_byte_reg <= pend_byte_next;
        out_item_reg  <= out_item_next;
    end

    // The pair table is read at the current code every cycle, so the entry
    // is ready in the cycle after a pair code is seen.
    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[in_item.table_index] <= {in_item.pair_first, in_item.pair_second};
        end
        pair_rd_reg <= pair_mem[cur_reg[bpe_pkg::TABLE_IDX_W-1:0]];
    end

    // The stack read port tracks the next top of stack, with a bypass for
    // the entry written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= pair_rd_reg[7:0];
        end
        if (stack_we && (stack_wa == stack_ra))
        begin
            stack_rd_reg <= pair_rd_reg[7:0];
        end
        else
        begin
            stack_rd_reg <= stack_mem[stack_ra];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/byte_pair_expander_top.sv */
// ============================================================================
// Byte-pair expander top level
// Decompresses byte-pair coded strings through a pair table and a stack.
// ============================================================================
//
//  Channel   Direction  Payload     Purpose
//  in_ch     sink       in_item_t   pair table loads and code bytes
//  out_ch    source     out_item_t  decoded bytes and end markers
//  cfg       write      16 bits     max_len, output capacity per string
//
// A load transaction is taken in ST_IDLE alone; an end marker passes through
// ST_MARK and a literal code through ST_EVAL. A pair code starts in ST_IDLE,
// goes through ST_EVAL and ST_PAIR for each pair lookup, as the pair table
// read is registered, and through ST_EVAL for each literal; an item that does
// not end on an emitted literal with nothing held back also passes ST_FLUSH.
// Reset empties the stack and the output register and loads max_len and the
// capacity with 65535; the pair table is undefined until written.
// A stalled output holds the expansion only when a byte must enter it.

`default_nettype none

module byte_pair_expander_top #(
    parameter int STACK_DEPTH = bpe_pkg::STACK_DEPTH_DEFAULT,
    parameter int MAX_EXPAND  = bpe_pkg::MAX_EXPAND_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    bpe_stream_if.sink       in_ch,
    bpe_stream_if.source     out_ch
);

    bpe_pkg::dp_cmd_t    cmd;
    bpe_pkg::dp_status_t status;
    logic                in_ready;

    assign in_ch.ready = in_ready;

    bpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bpe_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_EXPAND  (MAX_EXPAND)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_item  (in_ch.payload),
        .cmd      (cmd),
        .status   (status),
        .out_ch   (out_ch)
    );

    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.truncated |-> out_ch.payload.last_of_item)
        else $error("truncated flag on a result that is not the last");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.end_of_string |->
            out_ch.payload.out_byte == 8'd0 && out_ch.payload.last_of_item &&
            !out_ch.payload.truncated)
        else $error("malformed end marker");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == bpe_pkg::OP_LIT_POP |-> !status.stack_empty)
        else $error("pop from an empty stack");

    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.pend_valid)
        else $error("new transaction taken while a result is still held back");

endmodule

`default_nettype wire

/* bench/tb.sv */
// ============================================================================
// Byte-pair expander testbench
// Loads the pair table and feeds code bytes on the input stream. Every
// transaction is also run through a behavioral expander kept in this bench;
// the decoded bytes, end markers and flags on the output stream are checked
// in order against it, or against the plan's result for a typed plan row.
// ============================================================================
`default_nettype none

module tb;

    import bpe_pkg::*;

    localparam int EXP_DEPTH      = STACK_DEPTH_DEFAULT;
    localparam int EXP_CAP        = MAX_EXPAND_DEFAULT;
    localparam int SETTLE_CYCLES  = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 56;

    localparam out_item_t END_MARK = '{8'h00, 1'b1, 1'b1, 1'b0};

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    bpe_stream_if #(.payload_t(in_item_t))  in_ch ();
    bpe_stream_if #(.payload_t(out_item_t)) out_ch ();

    byte_pair_expander_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [15:0] pair_mem [PAIR_CODES];
    logic [15:0] string_limit;
    logic [15:0] bytes_left;
    out_item_t   fresh_results [$];
    out_item_t   pending_results [$];
    bit          row_typed;
    out_item_t   row_want;
    int          mismatches;
    int          stalled_cycles;
    int          pace;
    bit          quiet;
    bit          table_loaded [PAIR_CODES];
    logic [6:0]  loaded_list [$];

    function automatic void expand_item(in_item_t it);
        logic [7:0]  stk [EXP_DEPTH];
        logic [7:0]  cur;
        logic [15:0] entry;
        int          sp;
        int          lits;
        bit          trunc;
        bit          done;
        bit          have_held;
        out_item_t   held;
        fresh_results.delete();
        if (it.req_type == REQ_LOAD)
        begin
            pair_mem[it.table_index] = {it.pair_first, it.pair_second};
            return;
        end
        if (it.code_byte == CODE_END)
        begin
            fresh_results.push_back(END_MARK);
            bytes_left = string_limit;
            return;
        end
        cur = it.code_byte;
        sp = 0;
        lits = 0;
        trunc = 1'b0;
        done = 1'b0;
        have_held = 1'b0;
        held = '0;
        while (!done)
        begin
            if (cur[7])
            begin
                entry = pair_mem[cur[6:0]];
                if (sp + 2 > EXP_DEPTH)
                begin
                    trunc = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    stk[sp] = entry[7:0];
                    stk[sp + 1] = entry[15:8];
                    sp += 2;
                end
            end
            else if (lits >= EXP_CAP)
            begin
                trunc = 1'b1;
                done = 1'b1;
            end
            else
            begin
                lits++;
                if (bytes_left > 16'd1)
                begin
                    if (have_held)
                        fresh_results.push_back(held);
                    held.out_byte = cur;
                    held.end_of_string = 1'b0;
                    held.last_of_item = 1'b0;
                    held.truncated = 1'b0;
                    have_held = 1'b1;
                    bytes_left--;
                end
            end
            if (!done)
            begin
                if (sp == 0)
                    done = 1'b1;
                else
                begin
                    sp--;
                    cur = stk[sp];
                end
            end
        end
        if (have_held)
        begin
            held.last_of_item = 1'b1;
            held.truncated = trunc;
            fresh_results.push_back(held);
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("byte %02h arrived with nothing expected", got.out_byte));
            return;
        end
        want = pending_results.pop_front();
        if (got.out_byte != want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
        if (got.end_of_string != want.end_of_string)
            report_mismatch($sformatf("end_of_string %0b, expected %0b",
                                      got.end_of_string, want.end_of_string));
        if (got.last_of_item != want.last_of_item)
            report_mismatch($sformatf("last_of_item %0b, expected %0b",
                                      got.last_of_item, want.last_of_item));
        if (got.truncated != want.truncated)
            report_mismatch($sformatf("truncated %0b, expected %0b",
                                      got.truncated, want.truncated));
    endtask

    always @(posedge clk)
    begin : scoreboard
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.payload);
            if (in_ch.valid && in_ch.ready)
            begin
                expand_item(in_ch.payload);
                if (row_typed)
                    pending_results.push_back(row_want);
                else
                    foreach (fresh_results[i])
                        pending_results.push_back(fresh_results[i]);
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : result_pacing
        int stall_left;
        int beat;
        stall_left = 0;
        beat = 0;
        pace = 1;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (beat % 64 == 0)
                pace = $urandom_range(0, 2);
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && pace != 0 && $urandom_range(0, 6 - 2 * pace) == 0)
                stall_left = $urandom_range(1, 3);
            out_ch.ready <= (stall_left == 0);
        end
    end

    function automatic in_item_t load_req(logic [6:0] idx, logic [7:0] first_b,
                                          logic [7:0] second_b);
        in_item_t r;
        r = in_item_t'($urandom);
        r.req_type = REQ_LOAD;
        r.table_index = idx;
        r.pair_first = first_b;
        r.pair_second = second_b;
        return r;
    endfunction

    function automatic in_item_t code_req(logic [7:0] c);
        in_item_t r;
        r = in_item_t'($urandom);
        r.req_type = REQ_CODE;
        r.code_byte = c;
        return r;
    endfunction

    function automatic logic [7:0] pick_pair_code();
        if (loaded_list.size() == 0)
            return 8'($urandom_range(1, 127));
        return {1'b1, loaded_list[$urandom_range(0, loaded_list.size() - 1)]};
    endfunction

    function automatic logic [7:0] pick_pair_byte();
        if ($urandom_range(0, 99) < 35)
            return pick_pair_code();
        return {1'b0, 7'($urandom)};
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0: return CODE_END;
            1, 2, 3, 4: return 8'($urandom_range(1, 127));
            default: return pick_pair_code();
        endcase
    endfunction

    task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
        if (!quiet && pace != 0 && $urandom_range(0, 6 - 2 * pace) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        if (it.req_type == REQ_LOAD && !table_loaded[it.table_index])
        begin
            table_loaded[it.table_index] = 1'b1;
            loaded_list.push_back(it.table_index);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(logic [15:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        string_limit = value;
    endtask

    task automatic run_strings(int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(load_req(7'($urandom), pick_pair_byte(), pick_pair_byte()));
                else
                    send_item(code_req(pick_code()));
                sent++;
            end
            send_item(code_req(CODE_END));
            sent++;
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
    endtask

    initial
    begin : stimulus
        plan_row_t   plan [22];
        logic [15:0] limit;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        row_typed = 1'b0;
        row_want = '0;
        mismatches = 0;
        stalled_cycles = 0;
        quiet = 1'b0;
        string_limit = MAX_LEN_RESET;
        bytes_left = MAX_LEN_RESET;
        foreach (table_loaded[i])
            table_loaded[i] = 1'b0;

        plan[0]  = '{code_req(CODE_END), 1'b1, END_MARK};
        plan[1]  = '{code_req(8'h01), 1'b1, out_item_t'({8'h01, 1'b0, 1'b1, 1'b0})};
        plan[2]  = '{code_req(8'h7F), 1'b1, out_item_t'({8'h7F, 1'b0, 1'b1, 1'b0})};
        plan[3]  = '{load_req(7'd127, 8'hFF, 8'hFF), 1'b0, '0};
        plan[4]  = '{load_req(7'd0, 8'h00, 8'h7F), 1'b0, '0};
        plan[5]  = '{load_req(7'd1, 8'h41, 8'h42), 1'b0, '0};
        plan[6]  = '{code_req(8'h80), 1'b0, '0};
        plan[7]  = '{code_req(8'h81), 1'b0, '0};
        plan[8]  = '{code_req(8'hFF), 1'b0, '0};
        plan[9]  = '{load_req(7'd2, 8'h81, 8'h81), 1'b0, '0};
        plan[10] = '{code_req(8'h82), 1'b0, '0};
        plan[11] = '{load_req(7'd3, 8'h01, 8'h83), 1'b0, '0};
        plan[12] = '{code_req(8'h83), 1'b0, '0};
        plan[13] = '{load_req(7'd4, 8'h33, 8'hFF), 1'b0, '0};
        plan[14] = '{code_req(8'h84), 1'b0, '0};
        plan[15] = '{load_req(7'd5, 8'h82, 8'h82), 1'b0, '0};
        plan[16] = '{load_req(7'd6, 8'h85, 8'h85), 1'b0, '0};
        plan[17] = '{load_req(7'd7, 8'h86, 8'h86), 1'b0, '0};
        plan[18] = '{code_req(8'h87), 1'b0, '0};
        plan[19] = '{load_req(7'd8, 8'h87, 8'h87), 1'b0, '0};
        plan[20] = '{code_req(8'h88), 1'b0, '0};
        plan[21] = '{code_req(CODE_END), 1'b1, END_MARK};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].stim, plan[i].typed, plan[i].want);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: limit = 16'd1;
                1: limit = 16'd2;
                2: limit = 16'($urandom_range(3, 24));
                3: limit = 16'hFFFF;
                4: limit = 16'($urandom_range(25, 400));
                default: limit = 16'd9;
            endcase
            if (phase == 5)
                quiet = 1'b1;
            write_max_len(limit);
            run_strings(PHASE_ITEMS);
        end

        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
